// ===== hw/rtl/tfr_pkg.sv =====
// Shared types, widths and codes for the task FIFO with remove by id.
// Used by every module of the block but tfr_ram; depends on nothing.
package tfr_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int ETIME_W = 16;
    localparam int REC_W   = ID_W + PRIO_W + ETIME_W;
    localparam int CNT_W   = 5;

    // Field positions on the stream ports
    localparam int ID_LSB    = 0;
    localparam int PRIO_LSB  = ID_LSB + ID_W;
    localparam int ETIME_LSB = PRIO_LSB + PRIO_W;
    localparam int CNT_LSB   = ETIME_LSB + ETIME_W;
    localparam int EMPTY_BIT = CNT_LSB + CNT_W;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 48;

    localparam logic [1:0] K_ENQ   = 2'd0;
    localparam logic [1:0] K_DEQ   = 2'd1;
    localparam logic [1:0] K_REM   = 2'd2;
    localparam logic [1:0] K_CLR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [ETIME_W-1:0] etime;
    } t_rec;

    typedef struct packed {
        logic [1:0]       status;
        t_rec             rec;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_result;

    // Physical slot of the entry at offset off from the head
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(off);
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

// ===== hw/rtl/task_fifo_with_remove_by_id_unit.sv =====
// Top level of the task FIFO with remove by id.
// Depends on tfr_pkg, tfr_seq, tfr_ram and tfr_out.
//
//  channel  dir  handshake             payload
//  s        in   i_s_tvalid/o_s_tready tuser: kind; tdata: task_id, task_priority,
//                                      task_exec_time
//  m        out  o_m_tvalid/i_m_tready tuser: status; tdata: out_id, out_priority,
//                                      out_exec_time, entry_count, is_empty
//
// Enqueue, clear and any request refused at once finish in the execute state;
// dequeue adds a RAM read. Remove scans from the head until the id matches, then
// moves each later entry down one slot; a miss scans every entry. The single
// RAM read port and the one id comparator each serve one entry a cycle.
// Reset clears the count and head pointer; record contents stay unknown.
// A request is taken while an earlier result waits; its result is held
// until the output register frees.
module task_fifo_with_remove_by_id_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [tfr_pkg::S_DATA_W-1:0]  i_s_tdata,  // task_id, task_priority, task_exec_time
    input  logic [1:0]                    i_s_tuser,  // kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tfr_pkg::M_DATA_W-1:0]  o_m_tdata,  // out_id, out_priority, out_exec_time,
                                                      // entry_count, is_empty, 2 pad bits
    output logic [1:0]                    o_m_tuser   // status
);

    tfr_pkg::t_rec          req_rec;
    logic                   wr_en;
    logic [tfr_pkg::AW-1:0] wr_addr;
    tfr_pkg::t_rec          wr_data;
    logic [tfr_pkg::AW-1:0] rd_addr;
    tfr_pkg::t_rec          rd_data;
    logic                   out_free;
    logic                   load;
    tfr_pkg::t_result       result;

    assign req_rec.id    = i_s_tdata[tfr_pkg::ID_LSB +: tfr_pkg::ID_W];
    assign req_rec.prio  = i_s_tdata[tfr_pkg::PRIO_LSB +: tfr_pkg::PRIO_W];
    assign req_rec.etime = i_s_tdata[tfr_pkg::ETIME_LSB +: tfr_pkg::ETIME_W];

    tfr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req_kind  (i_s_tuser),
        .i_req_rec   (req_rec),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_out_free  (out_free),
        .o_load      (load),
        .o_result    (result)
    );

    tfr_ram #(
        .WIDTH (tfr_pkg::REC_W),
        .DEPTH (tfr_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tfr_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (result),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== hw/rtl/tfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module tfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                i_wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/tfr_seq.sv =====
// Sequencer of the task FIFO: circular-buffer pointers, one shared id
// comparator used once per cycle for search, and the compaction walk.
// Depends on tfr_pkg; drives the record RAM and the output stage.
module tfr_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [1:0]                  i_req_kind,
    input  tfr_pkg::t_rec               i_req_rec,
    output logic                        o_wr_en,
    output logic [tfr_pkg::AW-1:0]      o_wr_addr,
    output tfr_pkg::t_rec               o_wr_data,
    output logic [tfr_pkg::AW-1:0]      o_rd_addr,
    input  tfr_pkg::t_rec               i_rd_data,
    input  logic                        i_out_free,
    output logic                        o_load,
    output tfr_pkg::t_result            o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DEQ_RD = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [1:0]               r_kind, n_kind;
    tfr_pkg::t_rec            r_req, n_req;
    logic [tfr_pkg::AW-1:0]   r_head, n_head;
    logic [tfr_pkg::CW-1:0]   r_count, n_count;
    logic [tfr_pkg::CW-1:0]   r_idx, n_idx;
    logic [1:0]               r_status, n_status;
    tfr_pkg::t_rec            r_rec, n_rec;

    logic [tfr_pkg::CW-1:0]   idx_p1;
    logic [tfr_pkg::CW-1:0]   idx_p2;
    logic                     id_hit;

    assign idx_p1 = r_idx + tfr_pkg::CW'(1);
    assign idx_p2 = r_idx + tfr_pkg::CW'(2);
    assign id_hit = (i_rd_data.id == r_req.id);

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_req     = r_req;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_status  = r_status;
        n_rec     = r_rec;
        o_wr_en   = 1'b0;
        o_wr_addr = tfr_pkg::phys(r_head, r_count);
        o_wr_data = r_req;
        o_rd_addr = tfr_pkg::phys(r_head, idx_p1);
        o_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind  = i_req_kind;
                    n_req   = i_req_rec;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = tfr_pkg::ST_OK;
                n_rec    = '0;
                n_state  = S_DONE;
                unique case (r_kind)
                    tfr_pkg::K_ENQ: begin
                        if (r_count == tfr_pkg::CW'(tfr_pkg::DEPTH)) begin
                            n_status = tfr_pkg::ST_FULL;
                        end else begin
                            o_wr_en = 1'b1;
                            n_count = r_count + tfr_pkg::CW'(1);
                        end
                    end
                    tfr_pkg::K_DEQ: begin
                        if (r_count == '0) begin
                            n_status = tfr_pkg::ST_EMPTY;
                        end else begin
                            o_rd_addr = r_head;
                            n_state   = S_DEQ_RD;
                        end
                    end
                    tfr_pkg::K_REM: begin
                        if (r_count == '0) begin
                            n_status = tfr_pkg::ST_NOT_FOUND;
                        end else begin
                            o_rd_addr = r_head;
                            n_idx     = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    tfr_pkg::K_CLR: begin
                        n_count = '0;
                        n_head  = '0;
                    end
                    default: ;
                endcase
            end
            S_DEQ_RD: begin
                n_rec   = i_rd_data;
                n_head  = tfr_pkg::phys(r_head, tfr_pkg::CW'(1));
                n_count = r_count - tfr_pkg::CW'(1);
                n_state = S_DONE;
            end
            S_SCAN: begin
                // Read of the next entry is already under way
                if (id_hit) begin
                    if (idx_p1 == r_count) begin
                        n_count = r_count - tfr_pkg::CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (idx_p1 == r_count) begin
                    n_status = tfr_pkg::ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_SHIFT: begin
                // Move entry idx+1 down into idx, fetch idx+2
                o_wr_en   = 1'b1;
                o_wr_addr = tfr_pkg::phys(r_head, r_idx);
                o_wr_data = i_rd_data;
                o_rd_addr = tfr_pkg::phys(r_head, idx_p2);
                if (idx_p2 == r_count) begin
                    n_count = r_count - tfr_pkg::CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx = idx_p1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
        r_kind   <= n_kind;
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_rec    <= n_rec;
    end

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_result.status = r_status;
    assign o_result.rec    = r_rec;
    assign o_result.count  = tfr_pkg::CNT_W'(r_count);
    assign o_result.empty  = (r_count == '0);

endmodule

// ===== hw/rtl/tfr_out.sv =====
// Output register of the task FIFO: holds one finished result for the
// master-side stream. Depends on tfr_pkg.
module tfr_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  tfr_pkg::t_result              i_result,
    output logic                          o_free,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [tfr_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [1:0]                    o_m_tuser
);

    logic             r_valid;
    tfr_pkg::t_result r_result;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_result.status;
    assign o_m_tdata  = {2'b00, r_result.empty, r_result.count, r_result.rec.etime,
                         r_result.rec.prio, r_result.rec.id};

endmodule

// ===== hw/rtl/tfr_chk.sv =====
// Port-level checker for the task FIFO with remove by id, bound to the top.
// Depends on tfr_pkg for field positions and status codes.
module tfr_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [tfr_pkg::M_DATA_W-1:0]  o_m_tdata,
    input logic [1:0]                    o_m_tuser
);

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // Each request is busy after its accept: no accept right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request accepted in back-to-back cycles");

    // Empty flag implies a zero count
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[tfr_pkg::EMPTY_BIT] |->
            o_m_tdata[tfr_pkg::CNT_LSB +: tfr_pkg::CNT_W] == '0)
        else $error("empty flag with nonzero count");

    // Only a successful request carries a record
    a_zero_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != tfr_pkg::ST_OK |->
            o_m_tdata[tfr_pkg::CNT_LSB-1:0] == '0)
        else $error("record fields nonzero on failed request");

endmodule

bind task_fifo_with_remove_by_id_unit tfr_chk u_tfr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== sim/task_fifo_with_remove_by_id_unit_tb.sv =====
// Self-checking testbench for task_fifo_with_remove_by_id_unit: a queue of task records
// with enqueue, dequeue, remove by id and clear. Compares every result with an in-bench
// queue model. Depends on tfr_pkg and the RTL of the block only.
module task_fifo_with_remove_by_id_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 80;

    // Receiver stall patterns
    localparam int RX_STEADY = 0;
    localparam int RX_MOSTLY = 1;
    localparam int RX_TOGGLE = 2;
    localparam int RX_SPARSE = 3;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [tfr_pkg::S_DATA_W-1:0] i_s_tdata = '0;   // task_id, task_priority, task_exec_time
    logic [1:0]                   i_s_tuser = '0;   // kind
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [tfr_pkg::M_DATA_W-1:0] o_m_tdata;        // out_id, out_priority, out_exec_time,
                                                    // entry_count, is_empty
    logic [1:0]                   o_m_tuser;        // status

    task_fifo_with_remove_by_id_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    tfr_pkg::t_rec    queued_tasks[$];
    tfr_pkg::t_result pending_results[$];

    bit                           request_fires;
    bit                           result_fires;
    logic [tfr_pkg::M_DATA_W-1:0] result_data_seen;
    logic [1:0]                   result_status_seen;

    int errors = 0;
    int quiet_cycles = 0;
    int burst_left = 0;
    bit sender_gaps_on = 1'b1;
    int rx_hold_request = 0;
    int hold_left = 0;
    int rx_mode = RX_STEADY;
    int rx_mode_left = 0;
    int n_by_kind[4] = '{default: 0};
    int n_by_status[4] = '{default: 0};
    int n_results = 0;
    int peak_fill = 0;

    // Sample both handshakes at the falling edge ahead of the edge that completes them
    always @(negedge i_clk) begin
        request_fires = i_rst_n && i_s_tvalid && o_s_tready;
        result_fires = i_rst_n && o_m_tvalid && i_m_tready;
        result_data_seen = o_m_tdata;
        result_status_seen = o_m_tuser;
    end

    // Apply one operation to the queue model and return the result it yields
    function automatic tfr_pkg::t_result apply_task_op(input logic [1:0] kind,
                                                       input logic [15:0] id,
                                                       input logic [7:0] prio,
                                                       input logic [15:0] etime);
        tfr_pkg::t_result res;
        tfr_pkg::t_rec    rec;
        int               hit;
        int               i;
        res = '0;
        res.status = tfr_pkg::ST_OK;
        hit = -1;
        case (kind)
            tfr_pkg::K_ENQ: begin
                if (queued_tasks.size() >= tfr_pkg::DEPTH) begin
                    res.status = tfr_pkg::ST_FULL;
                end else begin
                    rec.id = id;
                    rec.prio = prio;
                    rec.etime = etime;
                    queued_tasks.push_back(rec);
                end
            end
            tfr_pkg::K_DEQ: begin
                if (queued_tasks.size() == 0) begin
                    res.status = tfr_pkg::ST_EMPTY;
                end else begin
                    res.rec = queued_tasks.pop_front();
                end
            end
            tfr_pkg::K_REM: begin
                for (i = 0; i < queued_tasks.size() && hit < 0; i++) begin
                    if (queued_tasks[i].id == id) begin
                        hit = i;
                    end
                end
                if (hit < 0) begin
                    res.status = tfr_pkg::ST_NOT_FOUND;
                end else begin
                    queued_tasks.delete(hit);
                end
            end
            default: begin
                queued_tasks.delete();
            end
        endcase
        res.count = tfr_pkg::CNT_W'(queued_tasks.size());
        res.empty = (queued_tasks.size() == 0);
        return res;
    endfunction

    // Offer one request, idling in bursts, and record its expected result on accept
    task automatic send_request(input logic [1:0] kind, input logic [15:0] id,
                                input logic [7:0] prio, input logic [15:0] etime);
        logic [tfr_pkg::S_DATA_W-1:0] word;
        tfr_pkg::t_result             res;
        int                           gap;
        word = '0;
        word[tfr_pkg::ID_LSB +: tfr_pkg::ID_W] = id;
        word[tfr_pkg::PRIO_LSB +: tfr_pkg::PRIO_W] = prio;
        word[tfr_pkg::ETIME_LSB +: tfr_pkg::ETIME_W] = etime;
        if (sender_gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 16);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= kind;
        i_s_tdata <= word;
        do @(posedge i_clk); while (!request_fires);
        res = apply_task_op(kind, id, prio, etime);
        pending_results.push_back(res);
        n_by_kind[kind]++;
        n_by_status[res.status]++;
        if (queued_tasks.size() > peak_fill) begin
            peak_fill = queued_tasks.size();
        end
    endtask

    // Drop valid and hold the sender until every expected result is back
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_request(input int enq_weight);
        int          roll;
        logic [1:0]  kind;
        logic [15:0] id;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            kind = tfr_pkg::K_CLR;
        end else if (roll < 3 + enq_weight) begin
            kind = tfr_pkg::K_ENQ;
        end else if ($urandom_range(0, 1) == 1) begin
            kind = tfr_pkg::K_DEQ;
        end else begin
            kind = tfr_pkg::K_REM;
        end
        // Aim most removes at a queued id; keep a small id pool so duplicates occur
        if (kind == tfr_pkg::K_REM && queued_tasks.size() > 0 && $urandom_range(0, 3) != 0) begin
            id = queued_tasks[$urandom_range(0, queued_tasks.size() - 1)].id;
        end else if ($urandom_range(0, 1) == 1) begin
            id = 16'($urandom_range(0, 7));
        end else begin
            id = 16'($urandom_range(0, 65535));
        end
        send_request(kind, id, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        tfr_pkg::t_result want;
        if (result_fires) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", result_data_seen);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(result_status_seen));
                check_field("out_id", 32'(want.rec.id),
                            32'(result_data_seen[tfr_pkg::ID_LSB +: tfr_pkg::ID_W]));
                check_field("out_priority", 32'(want.rec.prio),
                            32'(result_data_seen[tfr_pkg::PRIO_LSB +: tfr_pkg::PRIO_W]));
                check_field("out_exec_time", 32'(want.rec.etime),
                            32'(result_data_seen[tfr_pkg::ETIME_LSB +: tfr_pkg::ETIME_W]));
                check_field("entry_count", 32'(want.count),
                            32'(result_data_seen[tfr_pkg::CNT_LSB +: tfr_pkg::CNT_W]));
                check_field("is_empty", 32'(want.empty),
                            32'(result_data_seen[tfr_pkg::EMPTY_BIT]));
            end
        end
    end

    // Receiver: random stall patterns, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_request > 0) begin
            hold_left = rx_hold_request;
            rx_hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(RX_STEADY, RX_SPARSE);
                rx_mode_left = $urandom_range(20, 150);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_STEADY: i_m_tready <= 1'b1;
                RX_MOSTLY: i_m_tready <= ($urandom_range(0, 3) != 0);
                RX_TOGGLE: i_m_tready <= ~i_m_tready;
                default:   i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (request_fires || result_fires || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d cycles without a handshake", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_empty_queue();
        send_request(tfr_pkg::K_DEQ, 16'h0000, 8'hFF, 16'hFFFF);
        send_request(tfr_pkg::K_REM, 16'h0000, 8'h00, 16'h0000);
        send_request(tfr_pkg::K_CLR, 16'hFFFF, 8'hFF, 16'hFFFF);
        drain_results();
    endtask

    // Fill with extremes and duplicate ids, overflow, then remove at several positions
    task automatic test_full_and_order();
        int i;
        for (i = 0; i < tfr_pkg::DEPTH; i++) begin
            if (i == 0) begin
                send_request(tfr_pkg::K_ENQ, 16'h0000, 8'h00, 16'h0000);
            end else if (i == 1) begin
                send_request(tfr_pkg::K_ENQ, 16'hFFFF, 8'hFF, 16'hFFFF);
            end else begin
                send_request(tfr_pkg::K_ENQ, 16'h0100 + 16'(i % 5), 8'(i * 3), 16'(i * 100));
            end
        end
        send_request(tfr_pkg::K_ENQ, 16'hDEAD, 8'hAA, 16'h5555);
        send_request(tfr_pkg::K_REM, 16'h0102, 8'h00, 16'h0000);
        send_request(tfr_pkg::K_REM, 16'h7777, 8'h00, 16'h0000);
        send_request(tfr_pkg::K_REM, 16'hFFFF, 8'h00, 16'h0000);
        send_request(tfr_pkg::K_DEQ, 16'h0000, 8'h00, 16'h0000);
        send_request(tfr_pkg::K_CLR, 16'h0000, 8'h00, 16'h0000);
        drain_results();
    endtask

    // Hold the result side off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int i;
        sender_gaps_on = 1'b0;
        rx_hold_request = HOLD_OFF_CYCLES;
        for (i = 0; i < 40; i++) begin
            random_request(70);
        end
        drain_results();
        sender_gaps_on = 1'b1;
    endtask

    // Swing the queue between empty and full; every fourth segment sends without gaps
    task automatic test_random_mix();
        int seg;
        int i;
        for (seg = 0; seg < 14; seg++) begin
            sender_gaps_on = (seg % 4 != 3);
            for (i = 0; i < 50; i++) begin
                random_request((seg % 2 == 0) ? 70 : 25);
            end
        end
        drain_results();
        sender_gaps_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_full_and_order();
        test_backpressure();
        test_random_mix();
        repeat (tfr_pkg::DEPTH + 8) @(posedge i_clk);
        $display("requests: %0d enqueue, %0d dequeue, %0d remove, %0d clear; %0d results",
                 n_by_kind[tfr_pkg::K_ENQ], n_by_kind[tfr_pkg::K_DEQ],
                 n_by_kind[tfr_pkg::K_REM], n_by_kind[tfr_pkg::K_CLR], n_results);
        $display("outcomes: %0d ok, %0d empty, %0d id miss, %0d refused full; peak fill %0d",
                 n_by_status[tfr_pkg::ST_OK], n_by_status[tfr_pkg::ST_EMPTY],
                 n_by_status[tfr_pkg::ST_NOT_FOUND], n_by_status[tfr_pkg::ST_FULL],
                 peak_fill);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_ram.sv
hw/rtl/tfr_seq.sv
hw/rtl/tfr_out.sv
hw/rtl/task_fifo_with_remove_by_id_unit.sv
hw/rtl/tfr_chk.sv
sim/task_fifo_with_remove_by_id_unit_tb.sv
